// ===== src/lpbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Lidar packet byte parser package
// Phase codes, record kinds, field widths and register reset values shared by
// the parser logic and its checks.
// ----------------------------------------------------------------------------
package lpbp_pkg;

	// Field widths.
	localparam int ByteW   = 8;
	localparam int KindW   = 3;
	localparam int ValueW  = 32;
	localparam int PhaseW  = 3;
	localparam int CountW  = 7;
	localparam int CfgIdxW = 2;

	// Parser phases.
	localparam logic [PhaseW-1:0] PH_HUNT    = 3'd0;
	localparam logic [PhaseW-1:0] PH_AZIMUTH = 3'd1;
	localparam logic [PhaseW-1:0] PH_POINTS  = 3'd2;
	localparam logic [PhaseW-1:0] PH_TIME    = 3'd3;
	localparam logic [PhaseW-1:0] PH_GPS     = 3'd4;

	// Record kinds carried on the output tuser.
	localparam logic [KindW-1:0] KIND_AZIMUTH   = 3'd0;
	localparam logic [KindW-1:0] KIND_DISTANCE  = 3'd1;
	localparam logic [KindW-1:0] KIND_REFLECT   = 3'd2;
	localparam logic [KindW-1:0] KIND_TIME      = 3'd3;
	localparam logic [KindW-1:0] KIND_GPS_START = 3'd4;
	localparam logic [KindW-1:0] KIND_GPS_CHAR  = 3'd5;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_BLOCKS_PER_PACKET = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_POINTS_PER_BLOCK  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_GPS_PAYLOAD_LEN   = 2'd2;

	// Register reset values.
	localparam logic [3:0] BLOCKS_RST = 4'd12;
	localparam logic [5:0] POINTS_RST = 6'd32;
	localparam logic [7:0] GPS_RST    = 8'd84;

	// Flag bytes.
	localparam logic [ByteW-1:0] FLAG_HI   = 8'd255;
	localparam logic [ByteW-1:0] FLAG_LO   = 8'd238;
	localparam logic [ByteW-1:0] GPS_DOLLAR = 8'd36;
	localparam logic [ByteW-1:0] GPS_G     = 8'd71;

	// Largest number of points in a block and the byte count it implies.
	localparam logic [5:0]        MAX_POINTS = 6'd32;
	localparam logic [CountW-1:0] MAX_BYTES  = 7'd96;

	// Byte length of a block body: points clamped to 1..32, three bytes each.
	function automatic logic [CountW-1:0] point_limit(input logic [5:0] points);
		logic [5:0] p;
		begin
			p = points;
			if (p == 6'd0) p = 6'd1;
			if (p > MAX_POINTS) p = MAX_POINTS;
			point_limit = {1'b0, p} + {1'b0, p} + {1'b0, p};
		end
	endfunction

endpackage

// ===== src/lidar_packet_byte_parser_top.sv =====
// ----------------------------------------------------------------------------
// Lidar packet byte parser, top level
// Hunts a raw byte stream for data block and GPS flags and emits azimuth,
// distance, reflectivity, timestamp and GPS records.
// ----------------------------------------------------------------------------
// The parser takes one byte per beat on the slave side and sustains one byte
// per clock cycle unless stalled: every byte is decoded in the cycle it is
// accepted, the parse state is updated at that edge, and any record it produces
// lands in the output register at that edge. A byte yields zero or one record.
// The input stays ready while the output register is empty or being drained,
// so a record waiting for the downstream side stalls the input only when the
// output is not taken. While hunting, the block looks for FF EE (data block)
// or "$G" (GPS sentence); the flag is recognized on its second byte. A data
// block gives one azimuth record, then per point one distance record (value
// in 2 mm units) and one reflectivity record. After blocks_per_packet blocks
// a four byte timestamp is collected; the fifth byte is dropped, and the
// timestamp record is emitted when that fifth byte is taken. A GPS sentence
// gives a start record with value zero and then gps_payload_len character
// records; one more byte is dropped before hunting resumes. Configuration
// registers should be written only while the stream is idle.
// ----------------------------------------------------------------------------
module lidar_packet_byte_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// Byte input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	// Record output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] record_value
	output logic [2:0]  m_tuser    // [2:0] record_kind
);

	// Configuration registers.
	logic [3:0] blocks_per_packet_q;
	logic [5:0] points_per_block_q;
	logic [7:0] gps_payload_len_q;

	// Parse state.
	logic [lpbp_pkg::PhaseW-1:0] phase_q;
	logic [lpbp_pkg::ByteW-1:0]  prev_byte_q;
	logic [lpbp_pkg::CountW-1:0] byte_cnt_q;
	logic [1:0]                  byte_mod3_q;   // byte_cnt_q modulo three
	logic [7:0]                  blocks_seen_q;
	logic [2:0]                  asm_idx_q;
	logic [lpbp_pkg::ValueW-1:0] asm_val_q;
	logic [7:0]                  gps_left_q;

	// Next-state values.
	logic [lpbp_pkg::PhaseW-1:0] phase_d;
	logic [lpbp_pkg::ByteW-1:0]  prev_byte_d;
	logic [lpbp_pkg::CountW-1:0] byte_cnt_d;
	logic [1:0]                  byte_mod3_d;
	logic [7:0]                  blocks_seen_d;
	logic [2:0]                  asm_idx_d;
	logic [lpbp_pkg::ValueW-1:0] asm_val_d;
	logic [7:0]                  gps_left_d;

	// Record produced by the current byte.
	logic                        rec_emit;
	logic [lpbp_pkg::KindW-1:0]  rec_kind;
	logic [lpbp_pkg::ValueW-1:0] rec_value;

	// Output register.
	logic                        out_valid_q;
	logic [lpbp_pkg::KindW-1:0]  out_kind_q;
	logic [lpbp_pkg::ValueW-1:0] out_value_q;

	logic                        s_fire;
	logic [lpbp_pkg::CountW-1:0] cnt_inc;
	logic [1:0]                  mod3_inc;
	logic [lpbp_pkg::CountW-1:0] limit;

	assign s_tready = !out_valid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_kind_q;

	// The byte counter never passes 96, so the 7-bit increment cannot wrap.
	assign cnt_inc  = byte_cnt_q + 7'd1;
	assign mod3_inc = (byte_mod3_q == 2'd2) ? 2'd0 : byte_mod3_q + 2'd1;
	assign limit    = lpbp_pkg::point_limit(points_per_block_q);

	// Configuration writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_per_packet_q <= lpbp_pkg::BLOCKS_RST;
			points_per_block_q  <= lpbp_pkg::POINTS_RST;
			gps_payload_len_q   <= lpbp_pkg::GPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpbp_pkg::REG_BLOCKS_PER_PACKET: blocks_per_packet_q <= cfg_data[3:0];
				lpbp_pkg::REG_POINTS_PER_BLOCK:  points_per_block_q  <= cfg_data[5:0];
				lpbp_pkg::REG_GPS_PAYLOAD_LEN:   gps_payload_len_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Byte decoder: one pass of the phase machine per accepted byte.
	always_comb begin
		phase_d       = phase_q;
		prev_byte_d   = prev_byte_q;
		byte_cnt_d    = byte_cnt_q;
		byte_mod3_d   = byte_mod3_q;
		blocks_seen_d = blocks_seen_q;
		asm_idx_d     = asm_idx_q;
		asm_val_d     = asm_val_q;
		gps_left_d    = gps_left_q;
		rec_emit      = 1'b0;
		rec_kind      = lpbp_pkg::KIND_AZIMUTH;
		rec_value     = '0;

		unique case (phase_q)
			lpbp_pkg::PH_HUNT: begin
				if (prev_byte_q == lpbp_pkg::FLAG_HI && s_tdata == lpbp_pkg::FLAG_LO) begin
					// The flag byte itself gives no record.
					if (blocks_seen_q != 8'hFF) blocks_seen_d = blocks_seen_q + 8'd1;
					phase_d     = lpbp_pkg::PH_AZIMUTH;
					prev_byte_d = '0;
					asm_idx_d   = '0;
					asm_val_d   = '0;
				end else if (prev_byte_q == lpbp_pkg::GPS_DOLLAR
					&& s_tdata == lpbp_pkg::GPS_G) begin
					rec_emit    = 1'b1;
					rec_kind    = lpbp_pkg::KIND_GPS_START;
					gps_left_d  = gps_payload_len_q;
					phase_d     = lpbp_pkg::PH_GPS;
					prev_byte_d = '0;
				end else begin
					prev_byte_d = s_tdata;
				end
			end

			lpbp_pkg::PH_AZIMUTH: begin
				if (asm_idx_q == 3'd0) begin
					asm_val_d = {24'd0, s_tdata};
					asm_idx_d = 3'd1;
				end else begin
					rec_emit    = 1'b1;
					rec_kind    = lpbp_pkg::KIND_AZIMUTH;
					rec_value   = {16'd0, s_tdata, asm_val_q[7:0]};
					asm_idx_d   = '0;
					asm_val_d   = '0;
					byte_cnt_d  = '0;
					byte_mod3_d = '0;
					phase_d     = lpbp_pkg::PH_POINTS;
				end
			end

			lpbp_pkg::PH_POINTS: begin
				byte_cnt_d  = cnt_inc;
				byte_mod3_d = mod3_inc;
				if (mod3_inc != 2'd0) begin
					if (asm_idx_q == 3'd0) begin
						asm_val_d = {24'd0, s_tdata};
						asm_idx_d = 3'd1;
					end else begin
						// Distance doubled into 2 mm units.
						rec_emit  = 1'b1;
						rec_kind  = lpbp_pkg::KIND_DISTANCE;
						rec_value = {15'd0, s_tdata, asm_val_q[7:0], 1'b0};
						asm_idx_d = '0;
						asm_val_d = '0;
					end
				end else begin
					rec_emit  = 1'b1;
					rec_kind  = lpbp_pkg::KIND_REFLECT;
					rec_value = {24'd0, s_tdata};
				end
				if (cnt_inc >= limit) begin
					byte_cnt_d  = '0;
					byte_mod3_d = '0;
					asm_idx_d   = '0;
					asm_val_d   = '0;
					prev_byte_d = '0;
					phase_d     = (blocks_seen_q == {4'd0, blocks_per_packet_q})
						? lpbp_pkg::PH_TIME : lpbp_pkg::PH_HUNT;
				end
			end

			lpbp_pkg::PH_TIME: begin
				if (asm_idx_q[2] == 1'b0) begin
					case (asm_idx_q[1:0])
						2'd0:    asm_val_d = asm_val_q | {24'd0, s_tdata};
						2'd1:    asm_val_d = asm_val_q | {16'd0, s_tdata, 8'd0};
						2'd2:    asm_val_d = asm_val_q | {8'd0, s_tdata, 16'd0};
						default: asm_val_d = asm_val_q | {s_tdata, 24'd0};
					endcase
					asm_idx_d = asm_idx_q + 3'd1;
				end else begin
					rec_emit      = 1'b1;
					rec_kind      = lpbp_pkg::KIND_TIME;
					rec_value     = asm_val_q;
					asm_idx_d     = '0;
					asm_val_d     = '0;
					blocks_seen_d = '0;
					phase_d       = lpbp_pkg::PH_HUNT;
					prev_byte_d   = '0;
				end
			end

			lpbp_pkg::PH_GPS: begin
				if (gps_left_q != 8'd0) begin
					rec_emit   = 1'b1;
					rec_kind   = lpbp_pkg::KIND_GPS_CHAR;
					rec_value  = {24'd0, s_tdata};
					gps_left_d = gps_left_q - 8'd1;
				end else begin
					phase_d     = lpbp_pkg::PH_HUNT;
					prev_byte_d = '0;
				end
			end

			default: begin
				// Codes that mean nothing fall back to hunting.
				phase_d     = lpbp_pkg::PH_HUNT;
				prev_byte_d = '0;
				asm_idx_d   = '0;
				asm_val_d   = '0;
				byte_cnt_d  = '0;
				byte_mod3_d = '0;
			end
		endcase
	end

	// Parse state advances only on an accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= lpbp_pkg::PH_HUNT;
			prev_byte_q   <= '0;
			byte_cnt_q    <= '0;
			byte_mod3_q   <= '0;
			blocks_seen_q <= '0;
			asm_idx_q     <= '0;
			asm_val_q     <= '0;
			gps_left_q    <= '0;
		end else if (s_fire) begin
			phase_q       <= phase_d;
			prev_byte_q   <= prev_byte_d;
			byte_cnt_q    <= byte_cnt_d;
			byte_mod3_q   <= byte_mod3_d;
			blocks_seen_q <= blocks_seen_d;
			asm_idx_q     <= asm_idx_d;
			asm_val_q     <= asm_val_d;
			gps_left_q    <= gps_left_d;
		end
	end

	// Output register. A byte is accepted only when this register is empty or
	// being drained, so a new record never overwrites one still waiting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_fire && rec_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && rec_emit) begin
			out_kind_q  <= rec_kind;
			out_value_q <= rec_value;
		end
	end

`ifndef SYNTH
	// The phase machine only ever reaches its five defined phases.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= lpbp_pkg::PH_GPS)
		else $error("parser phase left its defined range");

	// The block byte counter never runs past the largest block body.
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q < lpbp_pkg::MAX_BYTES && byte_mod3_q != 2'd3)
		else $error("block byte counter out of range");

	// Distance records are even and fit in 17 bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == lpbp_pkg::KIND_DISTANCE
		|-> m_tdata[0] == 1'b0 && m_tdata[31:17] == 15'd0)
		else $error("distance record not doubled");

	// A GPS start record carries a zero value and leaves the parser in GPS phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && phase_q == lpbp_pkg::PH_HUNT && rec_kind == lpbp_pkg::KIND_GPS_START
		&& rec_emit |=> m_tvalid && m_tdata == 32'd0 && phase_q == lpbp_pkg::PH_GPS)
		else $error("GPS start record malformed");
`endif

endmodule
